[design/mia_pkg.sv]
// Shared constants for the adjugate matrix inverse block.
// No dependencies; imported by every module of the block.
`default_nettype none
package mia_pkg;
	localparam int DEF_MAX_SIZE   = 4;
	localparam int DEF_DATA_WIDTH = 32;
	localparam int FRAC_BITS      = 16;
	localparam int DIGIT_W        = 16;
	localparam int SIZE_W         = 3;
	localparam int SIZE_RESET     = 4;
	localparam int MIN_SIZE       = 2;
endpackage
`default_nettype wire

[design/mia_mul.sv]
// Shared fixed point multiplier: digit-serial magnitude product, round, saturate.
// Depends on mia_pkg.
`default_nettype none
module mia_mul #(
	parameter int DATA_WIDTH = mia_pkg::DEF_DATA_WIDTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic signed [DATA_WIDTH-1:0] a,
	input  wire logic signed [DATA_WIDTH-1:0] b,
	output logic                              done,
	output logic signed [DATA_WIDTH-1:0]      product
);
	import mia_pkg::*;

	localparam int W    = DATA_WIDTH;
	localparam int NDIG = (W + DIGIT_W - 1) / DIGIT_W;
	localparam int MBW  = NDIG * DIGIT_W;
	localparam int PW   = W + MBW;
	localparam int CW   = $clog2(NDIG + 1);
	localparam logic [PW-1:0] HALF_LSB = PW'(1) << (FRAC_BITS - 1);
	localparam logic [PW-1:0] LIM_NEG  = PW'(1) << (W - 1);
	localparam logic [PW-1:0] LIM_POS  = (PW'(1) << (W - 1)) - PW'(1);

	logic [W-1:0]         ma_q;
	logic [MBW-1:0]       mb_q;
	logic                 neg_q;
	logic [PW-1:0]        acc_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 rnd_q;
	logic                 done_q;
	logic signed [W-1:0]  product_q;
	logic [W-1:0]         a_mag;
	logic [W-1:0]         b_mag;
	logic [W+DIGIT_W-1:0] pp;
	logic [PW-1:0]        rnd;
	logic signed [W-1:0]  sat_val;

	always_comb begin
		a_mag = a[W-1] ? (~a + W'(1)) : a;
		b_mag = b[W-1] ? (~b + W'(1)) : b;
		pp    = ma_q * mb_q[MBW-1 -: DIGIT_W];
		rnd   = (acc_q + HALF_LSB) >> FRAC_BITS;
		if (neg_q) begin
			sat_val = (rnd > LIM_NEG) ? {1'b1, {(W-1){1'b0}}} : -rnd[W-1:0];
		end else begin
			sat_val = (rnd > LIM_POS) ? {1'b0, {(W-1){1'b1}}} : rnd[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			rnd_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NDIG - 1)) begin
					busy_q <= 1'b0;
					rnd_q  <= 1'b1;
				end
			end else if (rnd_q) begin
				rnd_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ma_q  <= a_mag;
			mb_q  <= MBW'(b_mag) << (MBW - W);
			neg_q <= a[W-1] ^ b[W-1];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= (acc_q << DIGIT_W) + PW'(pp);
			mb_q  <= mb_q << DIGIT_W;
		end
		if (rnd_q) begin
			product_q <= sat_val;
		end
	end

	assign done    = done_q;
	assign product = product_q;
endmodule
`default_nettype wire

[design/mia_div.sv]
// Shared restoring divider: rounded, saturated fixed point quotient cf / det.
// Depends on mia_pkg.
`default_nettype none
module mia_div #(
	parameter int DATA_WIDTH = mia_pkg::DEF_DATA_WIDTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic signed [DATA_WIDTH-1:0] num,
	input  wire logic signed [DATA_WIDTH-1:0] den,
	output logic                              done,
	output logic signed [DATA_WIDTH-1:0]      quotient
);
	import mia_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int NW = W + FRAC_BITS + 1;
	localparam int CW = $clog2(NW + 1);
	localparam logic [NW-1:0] LIM_NEG = NW'(1) << (W - 1);
	localparam logic [NW-1:0] LIM_POS = (NW'(1) << (W - 1)) - NW'(1);

	logic [NW-1:0]       n_q;
	logic [NW-1:0]       q_q;
	logic [W-1:0]        rem_q;
	logic [W-1:0]        d_q;
	logic                neg_q;
	logic [CW-1:0]       cnt_q;
	logic                busy_q;
	logic                fin_q;
	logic                done_q;
	logic signed [W-1:0] quotient_q;
	logic [W-1:0]        n_mag;
	logic [W-1:0]        d_mag;
	logic [W:0]          trial;
	logic                fits;
	logic signed [W-1:0] sat_val;

	always_comb begin
		n_mag = num[W-1] ? (~num + W'(1)) : num;
		d_mag = den[W-1] ? (~den + W'(1)) : den;
		trial = {rem_q, n_q[NW-1]};
		fits  = trial >= {1'b0, d_q};
		if (neg_q) begin
			sat_val = (q_q > LIM_NEG) ? {1'b1, {(W-1){1'b0}}} : -q_q[W-1:0];
		end else begin
			sat_val = (q_q > LIM_POS) ? {1'b0, {(W-1){1'b1}}} : q_q[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NW - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end else if (fin_q) begin
				fin_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// Numerator is |cf| << FRAC_BITS plus half the divisor, for rounding.
			n_q   <= (NW'(n_mag) << FRAC_BITS) + NW'(d_mag >> 1);
			d_q   <= d_mag;
			q_q   <= '0;
			rem_q <= '0;
			neg_q <= num[W-1] ^ den[W-1];
		end else if (busy_q) begin
			n_q   <= n_q << 1;
			q_q   <= {q_q[NW-2:0], fits};
			rem_q <= fits ? W'(trial - {1'b0, d_q}) : trial[W-1:0];
		end
		if (fin_q) begin
			quotient_q <= sat_val;
		end
	end

	assign done     = done_q;
	assign quotient = quotient_q;
endmodule
`default_nettype wire

[design/matrix_inverse_adjugate_top.sv]
// Top level of the adjugate matrix inverse: load memory, cofactor sequencer, output.
// Depends on mia_pkg, mia_mul and mia_div.
//
//  channel | direction | payload                               | accepted when
//  s_*     | in        | tdata: element_value; tlast: last     | s_tvalid && s_tready
//  m_*     | out       | tdata: result_value; tuser: singular; | m_tvalid && m_tready
//          |           | tlast: last_result                    |
//  cfg_*   | in        | cfg_wdata: matrix_size                | cfg_we
//
// Elements are taken one per cycle while loading. The marked element starts the
// computation and s_tready stays low until the last result has been transferred.
// Every cofactor is found by a depth-first expansion along the first row, one
// product at a time on the single shared multiplier; a 4x4 matrix takes 148
// products. Each result then uses the shared divider, unless the determinant is
// zero. m_tvalid holds a result until it is taken. Reset clears control state and
// sets matrix_size to 4; the memories are not cleared.
`default_nettype none
module matrix_inverse_adjugate_top #(
	parameter int MAX_SIZE   = mia_pkg::DEF_MAX_SIZE,
	parameter int DATA_WIDTH = mia_pkg::DEF_DATA_WIDTH
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// element_value in the low DATA_WIDTH bits, zero padded to whole bytes
	input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]      s_tdata,
	input  wire logic                                 s_tlast,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// result_value in the low DATA_WIDTH bits, zero padded to whole bytes
	output logic [((DATA_WIDTH+7)/8)*8-1:0]           m_tdata,
	// singular
	output logic                                      m_tuser,
	output logic                                      m_tlast,
	input  wire logic                                 cfg_we,
	input  wire logic [mia_pkg::SIZE_W-1:0]           cfg_wdata
);
	import mia_pkg::*;

	localparam int W    = DATA_WIDTH;
	localparam int TDW  = ((DATA_WIDTH + 7) / 8) * 8;
	localparam int AW   = W + $clog2(MAX_SIZE) + 1;
	localparam int NE   = MAX_SIZE * MAX_SIZE;
	localparam int IDXW = $clog2(NE);
	localparam int CNTW = $clog2(NE + 1);
	localparam int COLW = $clog2(MAX_SIZE + 1);
	localparam int TW   = 2 * COLW;
	localparam int LVL  = MAX_SIZE - 1;
	localparam int DEPW = (LVL > 1) ? $clog2(LVL) : 1;
	localparam int MW   = 1 << COLW;
	localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	typedef enum logic [14:0] {
		ST_LOAD      = 15'b000000000000001,
		ST_COF_START = 15'b000000000000010,
		ST_SCAN      = 15'b000000000000100,
		ST_LEAF_RD   = 15'b000000000001000,
		ST_LEAF      = 15'b000000000010000,
		ST_RET_RD    = 15'b000000000100000,
		ST_RET_MUL   = 15'b000000001000000,
		ST_RET_WAIT  = 15'b000000010000000,
		ST_DET_RD    = 15'b000000100000000,
		ST_DET_MUL   = 15'b000001000000000,
		ST_DET_WAIT  = 15'b000010000000000,
		ST_OUT_RD    = 15'b000100000000000,
		ST_OUT_DIV   = 15'b001000000000000,
		ST_OUT_WAIT  = 15'b010000000000000,
		ST_OUT_SEND  = 15'b100000000000000
	} state_t;

	function automatic logic signed [W-1:0] sat_acc(input logic signed [AW-1:0] v);
		if (v > AW'(MAXV)) begin
			return MAXV;
		end else if (v < AW'(MINV)) begin
			return MINV;
		end
		return v[W-1:0];
	endfunction

	state_t                state_q;
	logic [SIZE_W-1:0]     size_q;
	logic [COLW-1:0]       n_q;
	logic [CNTW-1:0]       cnt_q;
	logic [COLW-1:0]       q_q;
	logic [COLW-1:0]       p_q;
	logic [DEPW-1:0]       depth_q;
	logic [MW-1:0]         mask_q;
	logic [COLW-1:0]       col_q [LVL];
	logic                  pos_q [LVL];
	logic signed [AW-1:0]  acc_q [LVL];
	logic signed [W-1:0]   ret_q;
	logic [COLW-1:0]       k_q;
	logic signed [AW-1:0]  det_acc_q;
	logic signed [W-1:0]   det_q;
	logic [COLW-1:0]       oi_q;
	logic [COLW-1:0]       oj_q;
	logic signed [W-1:0]   res_q;
	logic                  sing_q;

	// Matrix and cofactor memories, each with one write and one registered read port.
	logic signed [W-1:0]   mat_mem [NE];
	logic signed [W-1:0]   cof_mem [NE];
	logic signed [W-1:0]   mat_rd_q;
	logic signed [W-1:0]   cof_rd_q;

	logic [COLW-1:0]       n_cur;
	logic [TW-1:0]         total;
	logic                  in_xfer;
	logic                  load_we;
	logic [COLW-1:0]       dep_ext;
	logic [COLW-1:0]       col_cur;
	logic [COLW-1:0]       row_sel;
	logic [COLW-1:0]       col_sel;
	logic [TW-1:0]         mat_addr_w;
	logic [TW-1:0]         cof_addr_w;
	logic                  leaf;
	logic                  fin_go;
	logic signed [W-1:0]   fin_val;
	logic                  cof_we;
	logic signed [W-1:0]   cof_wd;
	logic [TW-1:0]         cof_waddr;
	logic                  mul_start;
	logic signed [W-1:0]   mul_a;
	logic signed [W-1:0]   mul_b;
	logic                  mul_done;
	logic signed [W-1:0]   mul_p;
	logic signed [AW-1:0]  mul_ext;
	logic                  div_start;
	logic                  div_done;
	logic signed [W-1:0]   div_q;
	logic                  out_last;

	always_comb begin
		if (size_q < SIZE_W'(MIN_SIZE)) begin
			n_cur = COLW'(MIN_SIZE);
		end else if (size_q > SIZE_W'(MAX_SIZE)) begin
			n_cur = COLW'(MAX_SIZE);
		end else begin
			n_cur = COLW'(size_q);
		end
		total   = TW'(n_cur) * TW'(n_cur);
		in_xfer = s_tvalid && (state_q == ST_LOAD);
		load_we = in_xfer && (TW'(cnt_q) < total);

		// Row of the minor at the current depth skips the cofactor's own row.
		dep_ext = COLW'(depth_q);
		col_cur = col_q[depth_q];
		leaf    = (dep_ext + COLW'(2)) == n_q;
		if (state_q == ST_DET_RD) begin
			row_sel = '0;
			col_sel = k_q;
		end else begin
			row_sel = (dep_ext < q_q) ? dep_ext : dep_ext + COLW'(1);
			col_sel = col_cur;
		end
		mat_addr_w = TW'(row_sel) * TW'(n_q) + TW'(col_sel);
		if (state_q == ST_DET_RD) begin
			cof_addr_w = TW'(k_q);
		end else begin
			cof_addr_w = TW'(oj_q) * TW'(n_q) + TW'(oi_q);
		end

		// A level finishes when its columns are used up, or at once for a single element.
		fin_go  = ((state_q == ST_SCAN) && (col_cur == n_q)) || (state_q == ST_LEAF);
		fin_val = (state_q == ST_LEAF) ? mat_rd_q : sat_acc(acc_q[depth_q]);
		cof_we  = fin_go && (depth_q == '0);
		if ((q_q[0] ^ p_q[0]) == 1'b1) begin
			cof_wd = (fin_val == MINV) ? MAXV : -fin_val;
		end else begin
			cof_wd = fin_val;
		end
		cof_waddr = TW'(q_q) * TW'(n_q) + TW'(p_q);

		mul_start = (state_q == ST_RET_MUL) || (state_q == ST_DET_MUL);
		mul_a     = mat_rd_q;
		mul_b     = (state_q == ST_DET_MUL) ? cof_rd_q : ret_q;
		mul_ext   = {{(AW-W){mul_p[W-1]}}, mul_p};
		div_start = (state_q == ST_OUT_DIV) && (det_q != '0);
		out_last  = (oi_q == n_q - COLW'(1)) && (oj_q == n_q - COLW'(1));
	end

	always_ff @(posedge clk) begin
		if (load_we) begin
			mat_mem[cnt_q[IDXW-1:0]] <= s_tdata[W-1:0];
		end
		mat_rd_q <= mat_mem[mat_addr_w[IDXW-1:0]];
		if (cof_we) begin
			cof_mem[cof_waddr[IDXW-1:0]] <= cof_wd;
		end
		cof_rd_q <= cof_mem[cof_addr_w[IDXW-1:0]];
	end

	mia_mul #(.DATA_WIDTH(DATA_WIDTH)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_p)
	);

	mia_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (cof_rd_q),
		.den      (det_q),
		.done     (div_done),
		.quotient (div_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			size_q  <= SIZE_W'(SIZE_RESET);
			cnt_q   <= '0;
			n_q     <= COLW'(MAX_SIZE);
			q_q     <= '0;
			p_q     <= '0;
			depth_q <= '0;
			mask_q  <= '0;
			k_q     <= '0;
			oi_q    <= '0;
			oj_q    <= '0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (load_we) begin
						cnt_q <= cnt_q + CNTW'(1);
					end
					if (in_xfer && s_tlast) begin
						cnt_q   <= '0;
						n_q     <= n_cur;
						q_q     <= '0;
						p_q     <= '0;
						state_q <= ST_COF_START;
					end
				end
				ST_COF_START: begin
					depth_q  <= '0;
					mask_q   <= MW'(1) << p_q;
					col_q[0] <= '0;
					pos_q[0] <= 1'b0;
					acc_q[0] <= '0;
					state_q  <= ST_SCAN;
				end
				ST_SCAN, ST_LEAF: begin
					if (fin_go) begin
						if (depth_q == '0) begin
							if (p_q == n_q - COLW'(1)) begin
								p_q <= '0;
								if (q_q == n_q - COLW'(1)) begin
									k_q       <= '0;
									det_acc_q <= '0;
									state_q   <= ST_DET_RD;
								end else begin
									q_q     <= q_q + COLW'(1);
									state_q <= ST_COF_START;
								end
							end else begin
								p_q     <= p_q + COLW'(1);
								state_q <= ST_COF_START;
							end
						end else begin
							depth_q <= depth_q - DEPW'(1);
							ret_q   <= fin_val;
							state_q <= ST_RET_RD;
						end
					end else if (mask_q[col_cur]) begin
						col_q[depth_q] <= col_cur + COLW'(1);
					end else if (leaf) begin
						state_q <= ST_LEAF_RD;
					end else begin
						// Descend into the minor that drops this column.
						mask_q[col_cur]            <= 1'b1;
						depth_q                    <= depth_q + DEPW'(1);
						col_q[depth_q + DEPW'(1)] <= '0;
						pos_q[depth_q + DEPW'(1)] <= 1'b0;
						acc_q[depth_q + DEPW'(1)] <= '0;
					end
				end
				ST_LEAF_RD: begin
					state_q <= ST_LEAF;
				end
				ST_RET_RD: begin
					state_q <= ST_RET_MUL;
				end
				ST_RET_MUL: begin
					state_q <= ST_RET_WAIT;
				end
				ST_RET_WAIT: begin
					if (mul_done) begin
						acc_q[depth_q]  <= pos_q[depth_q] ? acc_q[depth_q] - mul_ext
						                                  : acc_q[depth_q] + mul_ext;
						pos_q[depth_q]  <= ~pos_q[depth_q];
						mask_q[col_cur] <= 1'b0;
						col_q[depth_q]  <= col_cur + COLW'(1);
						state_q         <= ST_SCAN;
					end
				end
				ST_DET_RD: begin
					state_q <= ST_DET_MUL;
				end
				ST_DET_MUL: begin
					state_q <= ST_DET_WAIT;
				end
				ST_DET_WAIT: begin
					if (mul_done) begin
						det_acc_q <= det_acc_q + mul_ext;
						k_q       <= k_q + COLW'(1);
						if (k_q == n_q - COLW'(1)) begin
							det_q   <= sat_acc(det_acc_q + mul_ext);
							oi_q    <= '0;
							oj_q    <= '0;
							state_q <= ST_OUT_RD;
						end else begin
							state_q <= ST_DET_RD;
						end
					end
				end
				ST_OUT_RD: begin
					state_q <= ST_OUT_DIV;
				end
				ST_OUT_DIV: begin
					if (det_q == '0) begin
						res_q   <= '0;
						sing_q  <= 1'b1;
						state_q <= ST_OUT_SEND;
					end else begin
						state_q <= ST_OUT_WAIT;
					end
				end
				ST_OUT_WAIT: begin
					if (div_done) begin
						res_q   <= div_q;
						sing_q  <= 1'b0;
						state_q <= ST_OUT_SEND;
					end
				end
				ST_OUT_SEND: begin
					if (m_tready) begin
						if (out_last) begin
							state_q <= ST_LOAD;
						end else if (oj_q == n_q - COLW'(1)) begin
							oj_q    <= '0;
							oi_q    <= oi_q + COLW'(1);
							state_q <= ST_OUT_RD;
						end else begin
							oj_q    <= oj_q + COLW'(1);
							state_q <= ST_OUT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_LOAD);
	assign m_tvalid = (state_q == ST_OUT_SEND);
	assign m_tdata  = TDW'(unsigned'(res_q));
	assign m_tuser  = sing_q;
	assign m_tlast  = out_last;
endmodule
`default_nettype wire
